/* rtl/scancode_translate_key_fifo_defines.svh */
// ----------------------------------------------------------------------------
// Scancode translator assertion macros
// Shared concurrent assertion wrappers on clk_i with rst_ni disable.
// ----------------------------------------------------------------------------
`ifndef SCANCODE_TRANSLATE_KEY_FIFO_DEFINES_SVH
`define SCANCODE_TRANSLATE_KEY_FIFO_DEFINES_SVH

// Check a same-cycle implication
`define STKF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Check a next-cycle implication
`define STKF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* rtl/stkf_pkg.sv */
// ----------------------------------------------------------------------------
// Scancode translator package
// Queue sizing, set 1 translation table and controller/datapath structs.
// ----------------------------------------------------------------------------
package stkf_pkg;

  localparam int unsigned FIFO_DEPTH = 128;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned ENTRY_W    = 9;

  localparam logic [7:0] EXT_PREFIX = 8'hE0;
  localparam logic [6:0] SC_UP      = 7'h48;
  localparam logic [6:0] SC_LEFT    = 7'h4B;
  localparam logic [6:0] SC_RIGHT   = 7'h4D;
  localparam logic [6:0] SC_DOWN    = 7'h50;
  localparam logic [7:0] KEY_UP     = 8'hAD;
  localparam logic [7:0] KEY_LEFT   = 8'hAC;
  localparam logic [7:0] KEY_RIGHT  = 8'hAE;
  localparam logic [7:0] KEY_DOWN   = 8'hAF;

  localparam logic [7:0] SCAN_TABLE [128] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h7F, 8'h09,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
    8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0D, 8'hA3, 8'h61, 8'h73,
    8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'hB6, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
    8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'hB6, 8'h2A,
    8'hB8, 8'hA2, 8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'hBE, 8'hBF,
    8'hC0, 8'hC1, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hAD,
    8'h00, 8'hAC, 8'hAE, 8'h00, 8'hAF, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hA3
  };

  // Commands from the controller to the datapath
  typedef struct packed {
    logic scan;       // take a scan byte
    logic pop;        // issue a queue read and advance the read pointer
    logic load_zero;  // load an empty-queue result
    logic load_data;  // load the popped entry as the result
  } stkf_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic empty;
  } stkf_status_t;

  // Translate the low 7 bits of a set 1 code to a game key
  function automatic logic [7:0] translate(input logic ext, input logic [6:0] code7);
    logic [7:0] key;
    key = SCAN_TABLE[code7];
    if (ext) begin
      unique case (code7)
        SC_UP:    key = KEY_UP;
        SC_LEFT:  key = KEY_LEFT;
        SC_RIGHT: key = KEY_RIGHT;
        SC_DOWN:  key = KEY_DOWN;
        default:  key = SCAN_TABLE[code7];
      endcase
    end
    return key;
  endfunction

endpackage

/* rtl/stkf_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module stkf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/stkf_datapath.sv */
// ----------------------------------------------------------------------------
// Scancode translator datapath
// Prefix flag, translation, queue pointers, key store and result register.
// ----------------------------------------------------------------------------
module stkf_datapath
  import stkf_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  stkf_cmd_t    cmd_i,
  input  logic [7:0]   scan_byte_i,
  output stkf_status_t status_o,
  output logic         key_available_o,
  output logic         key_pressed_o,
  output logic [7:0]   key_code_o
);

  logic               ext_q, ext_d;
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d, wr_next;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d, rd_next;
  logic               full;
  logic               push;
  logic [ENTRY_W-1:0] wdata;
  logic [ENTRY_W-1:0] rdata;
  logic               avail_q, avail_d;
  logic               pressed_q, pressed_d;
  logic [7:0]         code_q, code_d;

  // Wrap the pointers at the queue depth
  assign wr_next = (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
  assign rd_next = (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;

  assign full           = (wr_next == rd_ptr_q);
  assign status_o.empty = (wr_ptr_q == rd_ptr_q);

  // Push any non-prefix byte unless the queue is full
  assign push  = cmd_i.scan && (scan_byte_i != EXT_PREFIX) && !full;
  assign wdata = {~scan_byte_i[7], translate(ext_q, scan_byte_i[6:0])};

  always_comb begin
    ext_d    = ext_q;
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (cmd_i.scan) begin
      ext_d = (scan_byte_i == EXT_PREFIX);
    end
    if (push) begin
      wr_ptr_d = wr_next;
    end
    if (cmd_i.pop) begin
      rd_ptr_d = rd_next;
    end
  end

  // Hold the result word until the next load
  always_comb begin
    avail_d   = avail_q;
    pressed_d = pressed_q;
    code_d    = code_q;
    if (cmd_i.load_zero) begin
      avail_d   = 1'b0;
      pressed_d = 1'b0;
      code_d    = '0;
    end else if (cmd_i.load_data) begin
      avail_d   = 1'b1;
      pressed_d = rdata[8];
      code_d    = rdata[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_q    <= 1'b0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      ext_q    <= ext_d;
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    avail_q   <= avail_d;
    pressed_q <= pressed_d;
    code_q    <= code_d;
  end

  stkf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (FIFO_DEPTH)
  ) u_key_store (
    .clk_i   (clk_i),
    .we_i    (push),
    .waddr_i (wr_ptr_q),
    .wdata_i (wdata),
    .re_i    (cmd_i.pop),
    .raddr_i (rd_ptr_q),
    .rdata_o (rdata)
  );

  assign key_available_o = avail_q;
  assign key_pressed_o   = pressed_q;
  assign key_code_o      = code_q;

endmodule

/* rtl/stkf_ctrl.sv */
// ----------------------------------------------------------------------------
// Scancode translator controller
// Sequences input words, queue reads and the output handshake.
// ----------------------------------------------------------------------------
module stkf_ctrl
  import stkf_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  logic         in_kind_i,
  output logic         in_stall_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  input  stkf_status_t status_i,
  output stkf_cmd_t    cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_FETCH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_accept;
  logic   out_take;

  // Stall during a fetch or while a result word is blocked
  assign in_stall_o = (state_q == ST_FETCH) || (out_valid_q && out_stall_i);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_take   = out_valid_q && !out_stall_i;

  assign cmd_o.scan      = in_accept && !in_kind_i;
  assign cmd_o.pop       = in_accept && in_kind_i && !status_i.empty;
  assign cmd_o.load_zero = in_accept && in_kind_i && status_i.empty;
  assign cmd_o.load_data = (state_q == ST_FETCH);

  // Advance state and the output valid flag
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (cmd_o.load_zero || cmd_o.load_data) begin
      out_valid_d = 1'b1;
    end else if (out_take) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE:  if (cmd_o.pop) state_d = ST_FETCH;
      ST_FETCH: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* rtl/scancode_translate_key_fifo.sv */
// ----------------------------------------------------------------------------
// Scancode translator with key queue
// Translates set 1 keyboard bytes into game keys and queues them for reads.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one word: in_kind_i = 0
//   delivers a raw scan byte, in_kind_i = 1 requests one queued key.
//   A scan byte produces no result; 0xE0 arms the extended prefix, any other
//   byte is translated and queued, or dropped while the queue holds
//   FIFO_DEPTH-1 keys.
//   Output channel (out_valid_o / out_stall_i) returns one word per read:
//   key_available, press flag and key code, all zero for an empty queue.
//   Throughput: one scan byte per cycle while in_stall_o is low. A read of an
//   empty queue loads the result register and shows its result in the next
//   cycle. A read that pops a key passes through the registered read port of
//   the key store, then the result register; input stalls during the fetch.
//   While a result is stalled at the output register, in_stall_o is high and
//   no new word is taken; the result is held unchanged.
//   Reset clears the prefix flag, both queue pointers and the output valid;
//   the key store needs no clearing since only written entries are read.
// ----------------------------------------------------------------------------
`include "scancode_translate_key_fifo_defines.svh"

module scancode_translate_key_fifo
  import stkf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       in_kind_i,
  input  logic [7:0] in_scan_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       out_key_available_o,
  output logic       out_key_pressed_o,
  output logic [7:0] out_key_code_o
);

  stkf_cmd_t    cmd;
  stkf_status_t status;

  stkf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_kind_i   (in_kind_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  stkf_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .scan_byte_i     (in_scan_byte_i),
    .status_o        (status),
    .key_available_o (out_key_available_o),
    .key_pressed_o   (out_key_pressed_o),
    .key_code_o      (out_key_code_o)
  );

  // A pop is always followed by loading the fetched entry
  `STKF_ASSERT_NEXT(a_pop_then_load, cmd.pop, cmd.load_data)
  // No input word is taken while a fetch completes
  `STKF_ASSERT_IMPL(a_fetch_stalls_input, cmd.load_data, in_stall_o)
  // Never pop an empty queue
  `STKF_ASSERT_IMPL(a_no_pop_when_empty, status.empty, !cmd.pop)
  // A loaded key shows as available with valid raised
  `STKF_ASSERT_NEXT(a_load_data_valid, cmd.load_data, out_valid_o && out_key_available_o)

endmodule
